@@ design/chacha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg
// shared types and constants for the chacha keystream byte cipher
// ----------------------------------------------------------------------------
package chacha_pkg;
	localparam int unsigned REG_COUNT   = 8;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam logic [4:0]  ROUNDS_RST  = 5'd20;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY01   = 3'd0,
		REG_KEY23   = 3'd1,
		REG_KEY45   = 3'd2,
		REG_KEY67   = 3'd3,
		REG_NONCE01 = 3'd4,
		REG_NONCE2  = 3'd5,
		REG_CTR     = 3'd6,
		REG_ROUNDS  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // load initial state into working regs
		logic qr_step;   // run one half-quarter-round step (4 parallel lanes)
		logic finalize;  // add input words back into block
		logic emit;      // produce one output byte
		logic restart;   // config write: reset counter/position
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_block; // next byte needs a fresh block
		logic last_step;  // current step is last of the rounds
	} dp_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction
endpackage

@@ design/chacha_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_ctrl
// sequencer: takes an item, makes a block when needed, holds result
// ----------------------------------------------------------------------------
module chacha_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 cfg_ready,
	input  logic                 cfg_wr,
	input  chacha_pkg::dp_stat_t stat,
	output chacha_pkg::dp_cmd_t  cmd
);
	import chacha_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.restart = cfg_wr;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cfg_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// a register write wins over a new item
				cfg_ready = 1'b1;
				in_ready  = !cfg_wr;
				if (in_valid && !cfg_wr) begin
					if (stat.need_block) begin
						cmd.load = 1'b1;
						state_d  = ST_LOAD;
					end else begin
						cmd.emit = 1'b1;
						state_d  = ST_OUT;
					end
				end
			end
			ST_LOAD: begin
				if (stat.last_step) state_d = ST_FINAL;
				else state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (stat.last_step) state_d = ST_FINAL;
				else cmd.qr_step = 1'b1;
			end
			ST_FINAL: begin
				cmd.finalize = 1'b1;
				cmd.emit     = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					in_ready = 1'b1;
					if (in_valid) begin
						if (stat.need_block) begin
							cmd.load = 1'b1;
							state_d  = ST_LOAD;
						end else begin
							cmd.emit = 1'b1;
							state_d  = ST_OUT;
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

@@ design/chacha_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_dp
// datapath: key registers, round state, block store, byte select
// ----------------------------------------------------------------------------
module chacha_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                          data_byte,
	input  logic                                last_in,
	output logic [7:0]                          out_byte,
	output logic                                last_out,
	input  chacha_pkg::dp_cmd_t                 cmd,
	output chacha_pkg::dp_stat_t                stat
);
	import chacha_pkg::*;

	logic [63:0] key_q [4];
	logic [63:0] nonce01_q;
	logic [31:0] nonce2_q;
	logic [31:0] ctr_init_q;
	logic [4:0]  rounds_q;
	logic [31:0] counter_q;
	logic [5:0]  pos_q;
	logic        bvalid_q;
	logic [31:0] x_q   [16];
	logic [31:0] blk_q [16];
	logic [6:0]  step_q;   // half quarter-round steps, 4 per double round, up to 64
	logic [7:0]  byte_q;
	logic        last_q;
	logic [7:0]  din_q;

	logic [31:0] init_w [16];
	logic [5:0]  rounds_p1;
	logic [6:0]  steps_total;

	// each double round is 2 passes of 2 steps (each step = half a quarter round)
	assign rounds_p1   = {1'b0, rounds_q} + 6'd1;
	assign steps_total = {rounds_p1[5:1], 2'b00};

	always_comb begin
		init_w[0] = SIGMA0; init_w[1] = SIGMA1;
		init_w[2] = SIGMA2; init_w[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_w[4+2*i] = key_q[i][31:0];
			init_w[5+2*i] = key_q[i][63:32];
		end
		init_w[12] = counter_q;
		init_w[13] = nonce01_q[31:0];
		init_w[14] = nonce01_q[63:32];
		init_w[15] = nonce2_q;
	end

	assign stat.need_block = (pos_q == 6'd0) || !bvalid_q;
	assign stat.last_step  = (step_q == steps_total);

	// one step: half quarter round on four lanes, column or diagonal pass
	logic diag, second;
	logic [31:0] xn [16];
	assign diag   = step_q[1];
	assign second = step_q[0];

	always_comb begin
		logic [3:0] ia, ib, ic, id;
		logic [31:0] a, b, c, d;
		for (int k = 0; k < 16; k++) xn[k] = x_q[k];
		for (int l = 0; l < 4; l++) begin
			ia = 4'(l);
			ib = diag ? 4'(4 + ((l + 1) % 4)) : 4'(4 + l);
			ic = diag ? 4'(8 + ((l + 2) % 4)) : 4'(8 + l);
			id = diag ? 4'(12 + ((l + 3) % 4)) : 4'(12 + l);
			a = x_q[ia]; b = x_q[ib]; c = x_q[ic]; d = x_q[id];
			a = a + b; d = rotl(d ^ a, second ? 8 : 16);
			c = c + d; b = rotl(b ^ c, second ? 7 : 12);
			xn[ia] = a; xn[ib] = b; xn[ic] = c; xn[id] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce01_q  <= '0;
			nonce2_q   <= '0;
			ctr_init_q <= '0;
			rounds_q   <= ROUNDS_RST;
			counter_q  <= '0;
			pos_q      <= '0;
			bvalid_q   <= 1'b0;
			step_q     <= '0;
		end else if (cmd.restart) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_KEY01:   key_q[0]   <= cfg_data;
				REG_KEY23:   key_q[1]   <= cfg_data;
				REG_KEY45:   key_q[2]   <= cfg_data;
				REG_KEY67:   key_q[3]   <= cfg_data;
				REG_NONCE01: nonce01_q  <= cfg_data;
				REG_NONCE2:  nonce2_q   <= cfg_data[31:0];
				REG_CTR:     ctr_init_q <= cfg_data[31:0];
				REG_ROUNDS:  rounds_q   <= cfg_data[4:0];
				default: ;
			endcase
			counter_q <= (reg_idx_t'(cfg_idx) == REG_CTR) ? cfg_data[31:0] : ctr_init_q;
			pos_q     <= '0;
			bvalid_q  <= 1'b0;
		end else begin
			if (cmd.load) step_q <= '0;
			else if (cmd.qr_step) step_q <= step_q + 7'd1;
			if (cmd.finalize) bvalid_q <= 1'b1;
			if (cmd.emit) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					counter_q <= counter_q + 32'd1;
					bvalid_q  <= 1'b0;
				end
			end
		end
	end

	// payload registers
	logic [31:0] word_sel;
	logic [31:0] fin_word;
	assign fin_word = x_q[pos_q[5:2]] + init_w[pos_q[5:2]];
	assign word_sel = cmd.finalize ? fin_word : blk_q[pos_q[5:2]];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 16; i++) x_q[i] <= init_w[i];
			din_q  <= data_byte;
			last_q <= last_in;
		end else if (cmd.qr_step) begin
			for (int i = 0; i < 16; i++) x_q[i] <= xn[i];
		end
		if (cmd.finalize)
			for (int i = 0; i < 16; i++) blk_q[i] <= x_q[i] + init_w[i];
		if (cmd.emit) begin
			byte_q <= (cmd.finalize ? din_q : data_byte) ^ word_sel[8*pos_q[1:0] +: 8];
			if (!cmd.finalize) last_q <= last_in;
		end
	end

	assign out_byte = byte_q;
	assign last_out = last_q;
endmodule

@@ design/chacha_keystream_byte_cipher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_keystream_byte_cipher_core
// byte-serial chacha (ietf) stream cipher with configurable round count
// ----------------------------------------------------------------------------
// each accepted byte is xored with the next keystream byte; tlast rides along.
// a byte that starts a 64-byte block (or follows a config write) waits for the
// block to be made by one shared four-lane half-quarter-round unit, which
// steps through the rounds and then adds the input words back; other bytes
// are xored with the stored block and may follow back to back while the result
// register is drained. config writes are taken only while idle, with no result
// held, and win over a byte offered in that cycle.
module chacha_keystream_byte_cipher_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave item: tdata = data_byte[7:0]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,
	input  logic                                s_tlast,
	// master item: tdata = out_byte[7:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,
	output logic                                m_tlast,
	// register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import chacha_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     cfg_wr;

	// ready only while the sequencer is idle, so nothing is in flight
	assign cfg_wr = cfg_valid && cfg_ready;

	chacha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cfg_ready, .cfg_wr, .stat, .cmd
	);

	chacha_dp u_dp (
		.clk, .arst_n,
		.cfg_idx(cfg_index), .cfg_data,
		.data_byte(s_tdata), .last_in(s_tlast),
		.out_byte(m_tdata), .last_out(m_tlast),
		.cmd, .stat
	);
endmodule

@@ design/chacha_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_checker
// port-level checks for the cipher core
// ----------------------------------------------------------------------------
module chacha_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");
	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("accepted item while result stalled");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid || !s_tready)
		else $error("accepted item before result shown");
endmodule

bind chacha_keystream_byte_cipher_core chacha_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the chacha keystream byte cipher core
// ----------------------------------------------------------------------------
// bytes are streamed through the core while a local chacha predictor
// computes the expected ciphertext for every accepted item. the bench covers
// the default reset key, the extreme round counts, block counter wrap, a
// restart in the middle of a block, random keys and traffic under several
// idle and stall mixes, and a long receiver hold-off that fills the core.
module testbench;
	import chacha_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;	// data_byte[7:0]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;	// out_byte[7:0]
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state: register file, current block, counter, position
	logic [63:0] cfg_shadow [REG_COUNT];
	logic [31:0] keystream_words [16];
	logic [31:0] mix [16];
	logic [31:0] block_ctr;
	logic [5:0]  byte_pos;
	logic        block_ready;

	cipher_item_t expected_bytes [$];
	int          errors;
	int          sent_count;
	int          checked_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        recv_hold;

	chacha_keystream_byte_cipher_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the core hangs
	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void quarter_round(input int a, input int b, input int c, input int d);
		mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
		mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
		mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
		mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
	endfunction

	// builds one 64-byte keystream block from the shadow registers
	function automatic void build_keystream_block();
		logic [31:0] init [16];
		int doubles;
		init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2 * i] = cfg_shadow[i][31:0];
			init[5 + 2 * i] = cfg_shadow[i][63:32];
		end
		init[12] = block_ctr;
		init[13] = cfg_shadow[REG_NONCE01][31:0];
		init[14] = cfg_shadow[REG_NONCE01][63:32];
		init[15] = cfg_shadow[REG_NONCE2][31:0];
		doubles = (int'(cfg_shadow[REG_ROUNDS][4:0]) + 1) / 2;
		for (int i = 0; i < 16; i++) mix[i] = init[i];
		for (int r = 0; r < doubles; r++) begin
			quarter_round(0, 4, 8, 12);
			quarter_round(1, 5, 9, 13);
			quarter_round(2, 6, 10, 14);
			quarter_round(3, 7, 11, 15);
			quarter_round(0, 5, 10, 15);
			quarter_round(1, 6, 11, 12);
			quarter_round(2, 7, 8, 13);
			quarter_round(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) keystream_words[i] = mix[i] + init[i];
		block_ready = 1'b1;
	endfunction

	function automatic void restart_stream();
		block_ctr   = cfg_shadow[REG_CTR][31:0];
		byte_pos    = '0;
		block_ready = 1'b0;
	endfunction

	function automatic cipher_item_t encrypt_byte(input logic [7:0] data, input logic last);
		cipher_item_t r;
		logic [31:0] w;
		if (byte_pos == 0 || !block_ready) build_keystream_block();
		w = keystream_words[byte_pos[5:2]];
		r.data = data ^ w[8 * byte_pos[1:0] +: 8];
		r.last = last;
		byte_pos = byte_pos + 6'd1;
		if (byte_pos == 0) begin
			block_ctr   = block_ctr + 32'd1;
			block_ready = 1'b0;
		end
		return r;
	endfunction

	// receiver: random stall, or a forced hold-off
	always @(negedge clk)
		m_tready <= recv_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		cipher_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			checked_count++;
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected item out=%h last=%b", $time, m_tdata, m_tlast);
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data) begin
					errors++;
					$display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: last_out expected %b actual %b", $time, want.last, m_tlast);
				end
			end
		end
	end

	// one byte through the slave port; returns right after the accepting edge
	task automatic send_byte(input logic [7:0] data, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		expected_bytes.push_back(encrypt_byte(data, last));
		sent_count++;
	endtask

	// stop offering and wait for every expected item, plus slack for the core
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_NONCE2 || idx == REG_CTR) value = {32'd0, value[31:0]};
		else if (idx == REG_ROUNDS) value = {59'd0, value[4:0]};
		cfg_shadow[idx] = value;
		restart_stream();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pick_word64();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
	endtask

	// all-zero key at reset, 20 rounds, extreme and alternating-bit byte values
	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b1);
		drain();
	endtask

	// zero, one and two rounds, and the largest round count the field holds
	task automatic test_round_extremes();
		logic [4:0] rc [4] = '{5'd0, 5'd1, 5'd2, 5'd31};
		foreach (rc[i]) begin
			write_reg(REG_ROUNDS, {59'd0, rc[i]});
			send_byte(8'h00, 1'b0);
			send_byte(8'hff, 1'b1);
			send_byte(8'h3c, 1'b0);
		end
		write_reg(REG_ROUNDS, 64'd20);
	endtask

	// counter at all-ones: crossing the block boundary wraps it to zero
	task automatic test_counter_wrap();
		write_reg(REG_CTR, 64'hffff_ffff);
		send_random(70);
		drain();
	endtask

	// a register write in the middle of a block restarts the stream
	task automatic test_midblock_restart();
		send_random(10);
		write_reg(REG_KEY01, 64'h0123_4567_89ab_cdef);
		send_random(6);
		drain();
	endtask

	// random key, nonce, counter and rounds, then a random byte stream
	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		write_reg(REG_KEY01, pick_word64());
		write_reg(REG_KEY23, pick_word64());
		write_reg(REG_KEY45, pick_word64());
		write_reg(REG_KEY67, pick_word64());
		write_reg(REG_NONCE01, pick_word64());
		write_reg(REG_NONCE2, pick_word64());
		write_reg(REG_CTR, ($urandom_range(3) == 0) ? 64'hffff_fffe : {32'd0, $urandom});
		case ($urandom_range(3))
			0: write_reg(REG_ROUNDS, 64'd20);
			1: write_reg(REG_ROUNDS, 64'd8);
			default: write_reg(REG_ROUNDS, $urandom_range(31));
		endcase
		send_random(n);
		drain();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold      = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				recv_hold = 1'b0;
			end
			send_random(60);
		join
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		cfg_valid = 1'b0; cfg_index = REG_KEY01; cfg_data = '0;
		m_tready = 1'b0;
		recv_hold = 1'b0;
		send_idle_pct = 0; recv_stall_pct = 0;
		errors = 0; sent_count = 0; checked_count = 0;
		for (int i = 0; i < REG_COUNT; i++) cfg_shadow[i] = '0;
		cfg_shadow[REG_ROUNDS] = {59'd0, ROUNDS_RST};
		for (int i = 0; i < 16; i++) keystream_words[i] = '0;
		restart_stream();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_round_extremes();
		test_counter_wrap();
		test_midblock_restart();
		test_random_traffic(0, 0, 180);
		test_random_traffic(45, 0, 170);
		test_random_traffic(0, 45, 170);
		test_random_traffic(19, 19, 170);
		test_backpressure();
		drain();

		$display("covered: reset key, round counts 0/1/2/31, counter wrap, mid-block restart,");
		$display("random keys under idle and stall mixes, long hold-off: %0d sent, %0d checked",
			sent_count, checked_count);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

@@ chacha_keystream_byte_cipher_core.f @@
design/chacha_pkg.sv
design/chacha_ctrl.sv
design/chacha_dp.sv
design/chacha_keystream_byte_cipher_core.sv
design/chacha_checker.sv
tb/sv/testbench.sv
